// File: design/block_bump_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Block bump allocator: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUMP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BUMP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bump allocator package
// Widths, codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

	localparam int MAX_BLOCKS  = 256;
	localparam int MAX_RUN_DEF = 16;

	localparam int ADDR_W = 8;   // header store address
	localparam int TOP_W  = 9;   // top index, 0..MAX_BLOCKS
	localparam int CFG_W  = 9;
	localparam int SIZE_W = 16;
	localparam int HDR_W  = 6;
	localparam int RUN_W  = 5;   // block count of one allocation, 1..16
	localparam int IDX_W  = 4;   // block offset inside one allocation
	localparam int ACC_W  = 17;
	localparam int ST_W   = 2;

	localparam logic [CFG_W-1:0] BLOCK_BYTES_RST = 9'd16;
	localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 9'd0;

	// register indexes
	localparam logic REG_BLOCK_BYTES = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_SIZE   = 2'd1;
	localparam logic [ST_W-1:0] ST_SPACE  = 2'd2;
	localparam logic [ST_W-1:0] ST_HANDLE = 2'd3;

	// header bits: [0] free, [1] extended, [5:2] extra block count
	localparam logic [HDR_W-1:0] HDR_FREE = 6'b000001;

	typedef logic [ST_W-1:0] status_t;

	typedef struct packed {
		logic    load;
		logic    div_init;
		logic    div_step;
		logic    alloc_wr;
		logic    alloc_commit;
		logic    rd_handle;
		logic    rd_pos;
		logic    free_top;
		logic    free_mark;
		logic    walk_step;
		logic    walk_commit;
		logic    finish;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic size_zero;
		logic no_room;
		logic div_reached;
		logic n_at_max;
		logic n_over_room;
		logic handle_bad;
		logic is_top;
		logic alloc_last;
		logic walk_end;
		logic walk_over;
	} dp_stat_t;

endpackage

// File: design/bba_dp.sv
// ----------------------------------------------------------------------------
// Block bump allocator datapath
// Config registers, header store, top index, block-count divider and walk
// registers; moves on controller commands and on config writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_bump_allocator_unit_macros.svh"

module bba_dp #(
	parameter int MAX_RUN = bba_pkg::MAX_RUN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          kind,
	input  logic [bba_pkg::SIZE_W-1:0]    alloc_size,
	input  logic [bba_pkg::ADDR_W-1:0]    handle,
	input  logic                          handle_valid,
	input  bba_pkg::dp_cmd_t              cmd,
	output bba_pkg::dp_stat_t             stat,
	output logic                          done,
	output logic [bba_pkg::ST_W-1:0]      status,
	output logic [bba_pkg::ADDR_W-1:0]    block_index,
	output logic [bba_pkg::TOP_W-1:0]     top_index
);

	localparam int ADDR_W = bba_pkg::ADDR_W;
	localparam int TOP_W  = bba_pkg::TOP_W;
	localparam int HDR_W  = bba_pkg::HDR_W;
	localparam int RUN_W  = bba_pkg::RUN_W;
	localparam int IDX_W  = bba_pkg::IDX_W;
	localparam int ACC_W  = bba_pkg::ACC_W;
	localparam int NBLK   = bba_pkg::MAX_BLOCKS;

	// config and control state
	logic [bba_pkg::CFG_W-1:0] bb_q, bc_q;
	logic [TOP_W-1:0]          top_q;
	logic                      done_q;
	logic [NBLK-1:0]           vld_q;
	logic                      rd_vld_q;

	// request and work registers
	logic                       kind_q;
	logic [bba_pkg::SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0]          handle_q;
	logic                       hvalid_q;
	logic [ACC_W-1:0]           acc_q;
	logic [RUN_W-1:0]           n_q;
	logic [IDX_W-1:0]           i_q;
	logic [TOP_W-1:0]           pos_q, run_q;
	logic [ADDR_W-1:0]          head_q;
	bba_pkg::status_t           status_q;
	logic [ADDR_W-1:0]          bidx_q;
	logic [TOP_W-1:0]           topo_q;

	logic [HDR_W-1:0] hdr_mem [NBLK];
	logic [HDR_W-1:0] rd_hdr_q;

	logic [TOP_W-1:0]  cnt, payload, remain;
	logic [HDR_W-1:0]  hdr;
	logic [RUN_W-1:0]  blk, n_m1;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [HDR_W-1:0]  wr_data;

	assign cnt     = (bc_q > TOP_W'(NBLK)) ? TOP_W'(NBLK) : bc_q;
	assign payload = bb_q - TOP_W'(1);
	assign remain  = cnt - top_q;
	// entries never written since the last clear read as zero
	assign hdr     = rd_vld_q ? rd_hdr_q : '0;
	assign blk     = {1'b0, hdr[5:2]} + RUN_W'(1);
	assign n_m1    = n_q - RUN_W'(1);

	assign stat.kind        = kind_q;
	assign stat.size_zero   = (size_q == '0);
	assign stat.no_room     = (bb_q < 9'd2) || (top_q >= cnt);
	assign stat.div_reached = (acc_q >= {1'b0, size_q});
	assign stat.n_at_max    = (n_q == RUN_W'(MAX_RUN));
	assign stat.n_over_room = ({4'b0, n_q} > remain);
	assign stat.handle_bad  = !hvalid_q || ({1'b0, handle_q} >= top_q);
	assign stat.is_top      = (({2'b0, handle_q} + {5'b0, blk}) == {1'b0, top_q});
	assign stat.alloc_last  = ({1'b0, i_q} == n_m1);
	assign stat.walk_end    = (pos_q >= top_q);
	assign stat.walk_over   = (({1'b0, pos_q} + {5'b0, blk}) > {1'b0, top_q});

	assign wr_en   = cmd.alloc_wr | cmd.free_top | cmd.free_mark;
	assign rd_en   = cmd.rd_handle | cmd.rd_pos;
	assign rd_addr = cmd.rd_pos ? pos_q[ADDR_W-1:0] : handle_q;

	always_comb begin
		wr_addr = handle_q;
		wr_data = hdr | bba_pkg::HDR_FREE;
		if (cmd.alloc_wr) begin
			wr_addr = top_q[ADDR_W-1:0] + ADDR_W'(i_q);
			// head gets its run length, the extra blocks are cleared
			wr_data = (i_q == '0) ? {n_m1[3:0], (n_q > RUN_W'(1)), 1'b0} : '0;
		end else if (cmd.free_top) begin
			wr_data = bba_pkg::HDR_FREE;
		end
	end

	// header store
	always_ff @(posedge clk) begin
		if (wr_en)
			hdr_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_hdr_q <= hdr_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q     <= bba_pkg::BLOCK_BYTES_RST;
			bc_q     <= bba_pkg::BLOCK_COUNT_RST;
			top_q    <= '0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
			if (cfg_we) begin
				if (cfg_index == bba_pkg::REG_BLOCK_BYTES)
					bb_q <= cfg_data;
				else
					bc_q <= cfg_data;
				top_q <= '0;
				vld_q <= '0;
			end else begin
				if (wr_en)
					vld_q[wr_addr] <= 1'b1;
				if (cmd.alloc_commit)
					top_q <= top_q + TOP_W'(n_q);
				else if (cmd.free_top)
					top_q <= {1'b0, handle_q};
				else if (cmd.walk_commit)
					top_q <= top_q - run_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			size_q   <= alloc_size;
			handle_q <= handle;
			hvalid_q <= handle_valid;
			head_q   <= '0;
		end
		// ceil division by repeated addition of the block payload
		if (cmd.div_init) begin
			acc_q <= ACC_W'(payload);
			n_q   <= RUN_W'(1);
			i_q   <= '0;
		end else if (cmd.div_step) begin
			acc_q <= acc_q + ACC_W'(payload);
			n_q   <= n_q + RUN_W'(1);
		end
		if (cmd.alloc_wr)
			i_q <= i_q + IDX_W'(1);
		if (cmd.alloc_commit)
			head_q <= top_q[ADDR_W-1:0];
		if (cmd.free_top) begin
			pos_q <= '0;
			run_q <= '0;
		end else if (cmd.walk_step) begin
			pos_q <= pos_q + TOP_W'(blk);
			run_q <= hdr[0] ? run_q + TOP_W'(blk) : '0;
		end
		if (cmd.finish) begin
			status_q <= cmd.status;
			bidx_q   <= head_q;
			topo_q   <= top_q;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign block_index = bidx_q;
	assign top_index   = topo_q;

	`BBA_ASSERT_IMP(a_top_in_range, 1'b1, top_q <= cnt, "top index above usable block count")
	`BBA_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe held for more than one cycle")
	`BBA_ASSERT_IMP(a_err_no_index, done_q && (status_q != bba_pkg::ST_OK), bidx_q == '0, "block index not zero on error")

endmodule

// File: design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Block bump allocator controller
// Sequences check, division, header writes and the free walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_AWR   = 4'd3;
	localparam logic [3:0] S_FEVAL = 4'd4;
	localparam logic [3:0] S_WRD   = 4'd5;
	localparam logic [3:0] S_WEV   = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;

	logic [3:0]       state_q, state_d;
	bba_pkg::status_t st_q, st_d;

	always_comb begin
		state_d    = state_q;
		st_d       = st_q;
		cmd        = '0;
		cmd.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.kind == bba_pkg::KIND_ALLOC) begin
					if (stat.size_zero) begin
						st_d    = bba_pkg::ST_SIZE;
						state_d = S_DONE;
					end else if (stat.no_room) begin
						st_d    = bba_pkg::ST_SPACE;
						state_d = S_DONE;
					end else begin
						cmd.div_init = 1'b1;
						state_d      = S_DIV;
					end
				end else if (stat.handle_bad) begin
					st_d    = bba_pkg::ST_HANDLE;
					state_d = S_DONE;
				end else begin
					cmd.rd_handle = 1'b1;
					state_d       = S_FEVAL;
				end
			end
			S_DIV: begin
				if (stat.div_reached) begin
					if (stat.n_over_room) begin
						st_d    = bba_pkg::ST_SPACE;
						state_d = S_DONE;
					end else begin
						state_d = S_AWR;
					end
				end else if (stat.n_at_max) begin
					st_d    = bba_pkg::ST_SPACE;
					state_d = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_AWR: begin
				cmd.alloc_wr = 1'b1;
				if (stat.alloc_last) begin
					cmd.alloc_commit = 1'b1;
					st_d             = bba_pkg::ST_OK;
					state_d          = S_DONE;
				end
			end
			S_FEVAL: begin
				// topmost allocation: drop top, then walk for trailing free runs
				if (stat.is_top) begin
					cmd.free_top = 1'b1;
					state_d      = S_WRD;
				end else begin
					cmd.free_mark = 1'b1;
					st_d          = bba_pkg::ST_OK;
					state_d       = S_DONE;
				end
			end
			S_WRD: begin
				if (stat.walk_end) begin
					cmd.walk_commit = 1'b1;
					st_d            = bba_pkg::ST_OK;
					state_d         = S_DONE;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_WEV;
				end
			end
			S_WEV: begin
				if (stat.walk_over) begin
					cmd.walk_commit = 1'b1;
					st_d            = bba_pkg::ST_OK;
					state_d         = S_DONE;
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = S_WRD;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= bba_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: design/block_bump_allocator_unit.sv
// ----------------------------------------------------------------------------
// Block bump allocator unit
// Bump allocator over fixed blocks with one-byte headers; handles allocate
// and free requests against a header store and a top index.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  request  | start, busy            | kind, alloc_size, handle, handle_valid
//  result   | done (one-cycle pulse) | status, block_index, top_index
//  config   | cfg_we, cfg_index      | cfg_data
//
//  One request at a time; busy is high from the accepting edge until the
//  result strobe. Allocate: q division steps (n - 1, with n at most
//  MAX_RUN) and n header writes; a reject at the size check does neither.
//  Free: a bad handle is rejected, a plain free marks its head free;
//  freeing the topmost run walks the heads from block 0 to the top or an overrunning head.
//  Reset and any config write empty the store at once; results cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_bump_allocator_unit #(
	parameter int MAX_RUN = bba_pkg::MAX_RUN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [bba_pkg::SIZE_W-1:0]    alloc_size,
	input  logic [bba_pkg::ADDR_W-1:0]    handle,
	input  logic                          handle_valid,
	output logic                          done,
	output logic [bba_pkg::ST_W-1:0]      status,
	output logic [bba_pkg::ADDR_W-1:0]    block_index,
	output logic [bba_pkg::TOP_W-1:0]     top_index,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bba_pkg::CFG_W-1:0]     cfg_data
);

	bba_pkg::dp_cmd_t  cmd;
	bba_pkg::dp_stat_t stat;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bba_dp #(
		.MAX_RUN (MAX_RUN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.alloc_size   (alloc_size),
		.handle       (handle),
		.handle_valid (handle_valid),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.block_index  (block_index),
		.top_index    (top_index)
	);

endmodule
